[design/rle8bd_pkg.sv]
`default_nettype none
package rle8bd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WID_W   = 13;
  localparam int unsigned TOT_W   = 25;
  localparam int unsigned IDX_W   = 24;
  localparam int unsigned COL_W   = 12;
  localparam int unsigned ADV_W   = 21;
  localparam int unsigned CFG_W   = 25;
  localparam int unsigned CFGI_W  = 1;
  localparam int unsigned TAB_N   = 256;

  localparam logic [WID_W-1:0] MAX_WIDTH  = 13'd4096;
  localparam logic [TOT_W-1:0] MAX_PIXELS = 25'd16777216;

  localparam logic [CFGI_W-1:0] REG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFGI_W-1:0] REG_PIXEL_TOTAL = 1'b1;

  localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [BYTE_W-1:0] ESC_END   = 8'd1;
  localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_SECOND,
    PH_DX,
    PH_DY,
    PH_LITERAL,
    PH_PAD
  } phase_t;

  typedef struct packed {
    logic             busy;
    logic             norm_done;
    logic [COL_W-1:0] norm_col;
  } tab_status_t;

endpackage
`default_nettype wire

[design/rle8bd_if.sv]
`default_nettype none
interface rle8bd_in_if;
  logic                          valid;
  logic                          ready;
  logic [rle8bd_pkg::BYTE_W-1:0] stream_byte;
  logic                          stream_last;
  logic                          frame_start;

  modport source (output valid, output stream_byte, output stream_last, output frame_start,
                  input ready);
  modport sink (input valid, input stream_byte, input stream_last, input frame_start,
                output ready);
endinterface

interface rle8bd_out_if;
  logic                          valid;
  logic                          ready;
  logic [rle8bd_pkg::IDX_W-1:0]  write_index;
  logic [rle8bd_pkg::BYTE_W-1:0] write_value;
  logic [rle8bd_pkg::BYTE_W-1:0] write_count;
  logic                          image_done;

  modport source (output valid, output write_index, output write_value, output write_count,
                  output image_done, input ready);
  modport sink (input valid, input write_index, input write_value, input write_count,
                input image_done, output ready);
endinterface
`default_nettype wire

[design/rle8bd_mod_table.sv]
`default_nettype none
module rle8bd_mod_table (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [rle8bd_pkg::WID_W-1:0]   width,
  input  wire logic [rle8bd_pkg::COL_W-1:0]   col_raw,
  input  wire logic [rle8bd_pkg::BYTE_W-1:0]  rd_addr,
  output logic      [rle8bd_pkg::BYTE_W-1:0]  rd_data,
  output rle8bd_pkg::tab_status_t             status
);

  logic [rle8bd_pkg::BYTE_W-1:0] mem [rle8bd_pkg::TAB_N];

  logic                          active_r;
  logic                          settle_r;
  logic [rle8bd_pkg::BYTE_W-1:0] idx_r;
  logic [rle8bd_pkg::BYTE_W-1:0] acc_r;
  logic [rle8bd_pkg::BYTE_W-1:0] acc_nxt;
  logic [rle8bd_pkg::COL_W-1:0]  src_r;
  logic [rle8bd_pkg::COL_W-1:0]  rem_r;
  logic [rle8bd_pkg::COL_W-1:0]  rem_nxt;
  logic [rle8bd_pkg::COL_W:0]    rem_shift;
  logic [rle8bd_pkg::BYTE_W:0]   acc_inc;
  logic                          last_idx;

  // running value of index mod width, wrapping at width
  assign acc_inc = {1'b0, acc_r} + 9'd1;
  assign acc_nxt = (rle8bd_pkg::WID_W'(acc_inc) == width) ? '0 : acc_inc[rle8bd_pkg::BYTE_W-1:0];

  // one restoring step of column mod width, MSB first
  assign rem_shift = {rem_r, src_r[rle8bd_pkg::COL_W-1]};
  assign rem_nxt   = (rem_shift >= width) ? rle8bd_pkg::COL_W'(rem_shift - width)
                                          : rem_shift[rle8bd_pkg::COL_W-1:0];

  assign last_idx = (idx_r == rle8bd_pkg::BYTE_W'(rle8bd_pkg::TAB_N - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      settle_r <= 1'b0;
      idx_r    <= '0;
      acc_r    <= '0;
      src_r    <= '0;
      rem_r    <= '0;
    end else if (start) begin
      active_r <= 1'b1;
      settle_r <= 1'b0;
      idx_r    <= '0;
      acc_r    <= '0;
      src_r    <= col_raw;
      rem_r    <= '0;
    end else begin
      settle_r <= active_r && last_idx;
      if (active_r) begin
        idx_r <= idx_r + 8'd1;
        acc_r <= acc_nxt;
        if (last_idx) begin
          active_r <= 1'b0;
        end
        if (idx_r < rle8bd_pkg::BYTE_W'(rle8bd_pkg::COL_W)) begin
          rem_r <= rem_nxt;
          src_r <= {src_r[rle8bd_pkg::COL_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active_r) begin
      mem[idx_r] <= acc_r;
    end
    rd_data <= mem[rd_addr];
  end

  assign status.busy      = active_r | settle_r;
  assign status.norm_done = active_r && (idx_r == rle8bd_pkg::BYTE_W'(rle8bd_pkg::COL_W - 1));
  assign status.norm_col  = rem_nxt;

endmodule
`default_nettype wire

[design/rle8_bitmap_decoder_unit.sv]
`default_nettype none
// 8-bit run-length bitmap decoder. Takes one compressed byte per request on in_chan and
// emits at most one pixel write command (index, value, count, image_done) per byte on
// out_chan, in the cycle after the byte is taken when the output is free; a second output
// register lets one more byte enter while the last result waits, so the sustained rate is
// one byte per cycle while out_chan.ready stays high and the table is not being rebuilt;
// in_chan.ready never follows out_chan.ready in the same cycle. Column arithmetic uses a
// 256-entry table of x mod image_width held in block RAM; it is rebuilt after reset and
// after every image_width write, with in_chan.ready low while the rebuild runs (pixel_total
// writes take effect at once). image_done marks the end of an image, on a status-only
// result (write_count 0) when the ending byte writes nothing; after it, bytes are swallowed
// until one arrives with frame_start set. Clearing the frame buffer is the consumer's job.
module rle8_bitmap_decoder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rle8bd_in_if.sink                            in_chan,
  rle8bd_out_if.source                         out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [rle8bd_pkg::CFGI_W-1:0]   cfg_index,
  input  wire logic [rle8bd_pkg::CFG_W-1:0]    cfg_data
);

  localparam int unsigned BW = rle8bd_pkg::BYTE_W;
  localparam int unsigned WW = rle8bd_pkg::WID_W;
  localparam int unsigned TW = rle8bd_pkg::TOT_W;
  localparam int unsigned CW = rle8bd_pkg::COL_W;
  localparam int unsigned AW = rle8bd_pkg::ADV_W;
  localparam int unsigned IW = rle8bd_pkg::IDX_W;

  // configuration
  logic [WW-1:0] width_cfg_r;
  logic [TW-1:0] total_cfg_r;
  logic [WW-1:0] w_eff;
  logic [TW-1:0] t_eff;
  logic          width_wr;

  // decoder state
  rle8bd_pkg::phase_t phase_r, phase_nxt;
  logic [BW-1:0] held_r, held_nxt;
  logic [BW-1:0] lit_r, lit_nxt;
  logic          pad_r, pad_nxt;
  logic [BW-1:0] dx_r, dx_nxt;
  logic [TW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] col_raw_r, col_raw_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          fin_r, fin_nxt;

  // table
  rle8bd_pkg::tab_status_t tab_st;
  logic [BW-1:0] tab_addr;
  logic [BW-1:0] tab_rd;

  // output stage
  logic          out_valid_r;
  logic [IW-1:0] out_index_r;
  logic [BW-1:0] out_value_r;
  logic [BW-1:0] out_count_r;
  logic          out_done_r;
  logic          skid_valid_r;
  logic [IW-1:0] skid_index_r;
  logic [BW-1:0] skid_value_r;
  logic [BW-1:0] skid_count_r;
  logic          skid_done_r;
  logic          out_free;
  logic          res_push;

  logic          acc;
  logic          res_valid;
  logic [IW-1:0] res_index;
  logic [BW-1:0] res_value;
  logic [BW-1:0] res_count;
  logic          wrote;

  // step working values
  logic [TW-1:0] pos_c;
  logic [TW-1:0] room;
  logic          adv_en;
  logic [AW-1:0] adv_n;
  logic [CW-1:0] adv_col;
  logic [TW:0]   p_sum;
  logic [AW-1:0] dy_prod;
  logic [WW-1:0] col_tab;
  logic [CW-1:0] col_tab_wrap;
  logic [WW-1:0] col_inc;
  logic [CW-1:0] col_lit;
  logic [WW-1:0] eol_n;

  assign w_eff = (width_cfg_r == '0) ? WW'(1) :
                 (width_cfg_r > rle8bd_pkg::MAX_WIDTH) ? rle8bd_pkg::MAX_WIDTH : width_cfg_r;
  assign t_eff = (total_cfg_r == '0) ? TW'(1) :
                 (total_cfg_r > rle8bd_pkg::MAX_PIXELS) ? rle8bd_pkg::MAX_PIXELS : total_cfg_r;

  assign width_wr = cfg_we && (cfg_index == rle8bd_pkg::REG_IMAGE_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r <= WW'(1);
      total_cfg_r <= TW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rle8bd_pkg::REG_IMAGE_WIDTH: width_cfg_r <= cfg_data[WW-1:0];
        rle8bd_pkg::REG_PIXEL_TOTAL: total_cfg_r <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = !tab_st.busy && !skid_valid_r;
  assign acc = in_chan.valid && in_chan.ready;

  // table read follows the byte whose residue the next step will need
  always_comb begin
    if (acc && !(fin_r && !in_chan.frame_start) &&
        ((in_chan.frame_start || phase_r == rle8bd_pkg::PH_COUNT ||
          phase_r == rle8bd_pkg::PH_DX))) begin
      tab_addr = in_chan.stream_byte;
    end else if (phase_r == rle8bd_pkg::PH_DY) begin
      tab_addr = dx_r;
    end else begin
      tab_addr = held_r;
    end
  end

  rle8bd_mod_table u_tab (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (width_wr),
    .width   (w_eff),
    .col_raw (col_raw_r),
    .rd_addr (tab_addr),
    .rd_data (tab_rd),
    .status  (tab_st)
  );

  assign dy_prod      = AW'(in_chan.stream_byte) * AW'(w_eff);
  assign col_tab      = WW'(col_r) + WW'(tab_rd);
  assign col_tab_wrap = (col_tab >= w_eff) ? CW'(col_tab - w_eff) : col_tab[CW-1:0];
  assign col_inc      = WW'(col_r) + WW'(1);
  assign col_lit      = (col_inc == w_eff) ? '0 : col_inc[CW-1:0];
  assign eol_n        = w_eff - WW'(col_r);

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    lit_nxt     = lit_r;
    pad_nxt     = pad_r;
    dx_nxt      = dx_r;
    pos_nxt     = pos_r;
    col_raw_nxt = col_raw_r;
    col_nxt     = col_r;
    fin_nxt     = fin_r;
    wrote       = 1'b0;
    res_valid   = 1'b0;
    res_index   = '0;
    res_value   = '0;
    res_count   = '0;
    adv_en      = 1'b0;
    adv_n       = '0;
    adv_col     = '0;
    pos_c       = '0;
    room        = '0;
    p_sum       = '0;

    if (acc) begin
      if (in_chan.frame_start) begin
        phase_nxt   = rle8bd_pkg::PH_COUNT;
        held_nxt    = '0;
        lit_nxt     = '0;
        pad_nxt     = 1'b0;
        dx_nxt      = '0;
        pos_nxt     = '0;
        col_raw_nxt = '0;
        col_nxt     = '0;
        fin_nxt     = 1'b0;
      end

      if (!fin_nxt) begin
        // pull the position back inside a shrunk image
        pos_c   = (pos_nxt > t_eff) ? t_eff : pos_nxt;
        pos_nxt = pos_c;
        room    = t_eff - pos_c;

        unique case (phase_nxt)
          rle8bd_pkg::PH_SECOND: begin
            phase_nxt = rle8bd_pkg::PH_COUNT;
            if (held_nxt != '0) begin
              wrote     = 1'b1;
              res_index = pos_c[IW-1:0];
              res_value = in_chan.stream_byte;
              res_count = (TW'(held_nxt) < room) ? held_nxt : room[BW-1:0];
              adv_en    = 1'b1;
              adv_n     = AW'(held_nxt);
              adv_col   = col_tab_wrap;
            end else begin
              unique case (in_chan.stream_byte)
                rle8bd_pkg::ESC_EOL: begin
                  if (col_nxt != '0) begin
                    adv_en  = 1'b1;
                    adv_n   = AW'(eol_n);
                    adv_col = '0;
                  end
                end
                rle8bd_pkg::ESC_END:   fin_nxt   = 1'b1;
                rle8bd_pkg::ESC_DELTA: phase_nxt = rle8bd_pkg::PH_DX;
                default: begin
                  lit_nxt   = in_chan.stream_byte;
                  pad_nxt   = in_chan.stream_byte[0];
                  phase_nxt = rle8bd_pkg::PH_LITERAL;
                end
              endcase
            end
          end
          rle8bd_pkg::PH_DX: begin
            dx_nxt    = in_chan.stream_byte;
            phase_nxt = rle8bd_pkg::PH_DY;
          end
          rle8bd_pkg::PH_DY: begin
            phase_nxt = rle8bd_pkg::PH_COUNT;
            adv_en    = 1'b1;
            adv_n     = AW'(dx_nxt) + dy_prod;
            adv_col   = col_tab_wrap;
          end
          rle8bd_pkg::PH_LITERAL: begin
            wrote     = 1'b1;
            res_index = pos_c[IW-1:0];
            res_value = in_chan.stream_byte;
            res_count = BW'(1);
            adv_en    = 1'b1;
            adv_n     = AW'(1);
            adv_col   = col_lit;
            lit_nxt   = lit_nxt - BW'(1);
            if (lit_nxt == '0) begin
              phase_nxt = pad_nxt ? rle8bd_pkg::PH_PAD : rle8bd_pkg::PH_COUNT;
            end
          end
          rle8bd_pkg::PH_PAD: begin
            pad_nxt   = 1'b0;
            phase_nxt = rle8bd_pkg::PH_COUNT;
          end
          default: begin
            held_nxt  = in_chan.stream_byte;
            phase_nxt = rle8bd_pkg::PH_SECOND;
          end
        endcase

        if (adv_en) begin
          p_sum = {1'b0, pos_c} + (TW+1)'(adv_n);
          if (p_sum >= {1'b0, t_eff}) begin
            pos_nxt = t_eff;
            fin_nxt = 1'b1;
          end else begin
            pos_nxt = p_sum[TW-1:0];
          end
          col_raw_nxt = adv_col;
          col_nxt     = adv_col;
        end

        // an unfinished pair, delta or run is dropped at stream end
        if (in_chan.stream_last) begin
          fin_nxt = 1'b1;
        end

        res_valid = wrote || fin_nxt;
        if (!wrote) begin
          res_index = pos_nxt[IW-1:0];
        end
      end
    end

    if (tab_st.norm_done) begin
      col_nxt = tab_st.norm_col;
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign res_push = acc && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rle8bd_pkg::PH_COUNT;
      held_r       <= '0;
      lit_r        <= '0;
      pad_r        <= 1'b0;
      dx_r         <= '0;
      pos_r        <= '0;
      col_raw_r    <= '0;
      col_r        <= '0;
      fin_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      lit_r     <= lit_nxt;
      pad_r     <= pad_nxt;
      dx_r      <= dx_nxt;
      pos_r     <= pos_nxt;
      col_raw_r <= col_raw_nxt;
      col_r     <= col_nxt;
      fin_r     <= fin_nxt;
      if (out_free) begin
        out_valid_r  <= skid_valid_r || res_push;
        skid_valid_r <= 1'b0;
      end else if (res_push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // hold the payload until taken; park a new result beside a waiting one
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_index_r <= skid_index_r;
        out_value_r <= skid_value_r;
        out_count_r <= skid_count_r;
        out_done_r  <= skid_done_r;
      end else if (res_push) begin
        out_index_r <= res_index;
        out_value_r <= res_value;
        out_count_r <= res_count;
        out_done_r  <= fin_nxt;
      end
    end else if (res_push) begin
      skid_index_r <= res_index;
      skid_value_r <= res_value;
      skid_count_r <= res_count;
      skid_done_r  <= fin_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.write_index = out_index_r;
  assign out_chan.write_value = out_value_r;
  assign out_chan.write_count = out_count_r;
  assign out_chan.image_done  = out_done_r;

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r != '0 || out_done_r))
    else $error("status-only result without image_done");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_valid && fin_nxt) |=> fin_r)
    else $error("image ended but decoder not finished");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    !tab_st.busy |-> (WW'(col_r) < w_eff))
    else $error("column outside row");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= rle8bd_pkg::MAX_PIXELS)
    else $error("pixel position beyond frame");

endmodule
`default_nettype wire
